// File: rtl/sbg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sequential box grouping NMS block.
// Depends on nothing; every other file in rtl/ imports it.
package sbg_pkg;

  // Fixed field widths of the external payload.
  localparam int SBG_LABEL_W = 8;
  localparam int SBG_SCORE_W = 16;
  localparam int SBG_COORD_W = 16;
  localparam int SBG_THR_W   = 16;

  // IoU threshold after reset: 0.80 in unsigned Q0.16, rounded.
  localparam logic [SBG_THR_W-1:0] SBG_THR_RESET = 16'd52429;

  // Defaults of the top level parameters.
  localparam int SBG_COORD_BITS_DEF  = 16;
  localparam int SBG_LABEL_BITS_DEF  = 8;
  localparam int SBG_QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic [SBG_LABEL_W-1:0] class_label;
    logic [SBG_SCORE_W-1:0] score;
    logic [SBG_COORD_W-1:0] box_x0;
    logic [SBG_COORD_W-1:0] box_y0;
    logic [SBG_COORD_W-1:0] box_x1;
    logic [SBG_COORD_W-1:0] box_y1;
    logic                   last_box;
  } sbg_in_t;

  typedef struct packed {
    logic [SBG_LABEL_W-1:0] out_label;
    logic [SBG_SCORE_W-1:0] out_score;
    logic [SBG_COORD_W-1:0] out_x0;
    logic [SBG_COORD_W-1:0] out_y0;
    logic [SBG_COORD_W-1:0] out_x1;
    logic [SBG_COORD_W-1:0] out_y1;
    logic                   out_last;
  } sbg_out_t;

  // Status of the item queue.
  typedef struct packed {
    logic full;
    logic empty;
  } sbg_q_stat_t;

  // Status of the back end.
  typedef struct packed {
    logic group_open;
    logic idle;
  } sbg_back_stat_t;

endpackage

// File: rtl/sequential_box_grouping_nms_core.sv
`timescale 1ns / 1ps
// Top level of the sequential box grouping NMS block: front end, item
// queue and back end. Depends on sbg_pkg, sbg_front, sbg_queue, sbg_back.
//
//   Port group  Direction  Handshake              Payload
//   in_*        input      in_valid / in_ready    sbg_in_t, one box per transfer
//   out_*       output     out_valid / out_ready  sbg_out_t, one leader per transfer
//   cfg_*       input      cfg_valid / cfg_ready  16-bit IoU threshold, Q0.16
//
// A box that is tested against a leader of the same class goes through the back end
// as a pop, seven steps of the shared multiplier sequence (leader area, box area,
// overlap, union, two threshold partial products, the compare) and an update of the
// leader. Any other box is popped and then applied. A box marked last also flushes
// the group. The front end keeps taking transfers until the queue fills, and the
// output register lets the back end stall on a full output only when it has a
// leader to emit.
// Reset is synchronous, empties the queue, closes the group and returns the
// threshold to 0.80.
module sequential_box_grouping_nms_core
  import sbg_pkg::*;
#(
  parameter int COORD_BITS  = SBG_COORD_BITS_DEF,
  parameter int LABEL_BITS  = SBG_LABEL_BITS_DEF,
  parameter int QUEUE_DEPTH = SBG_QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sbg_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sbg_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [SBG_THR_W-1:0] cfg_data
);

  // One queue entry: label, score, four corners, two extents and the last flag.
  localparam int ITEM_W = LABEL_BITS + SBG_SCORE_W + 6 * COORD_BITS + 1;

  sbg_q_stat_t    q_stat;
  sbg_back_stat_t b_stat;
  logic           q_push, q_pop;
  logic [ITEM_W-1:0] q_wdata, q_rdata;

  // Front end outputs, already trimmed to the internal widths.
  logic [LABEL_BITS-1:0]  f_label;
  logic [SBG_SCORE_W-1:0] f_score;
  logic [COORD_BITS-1:0]  f_x0, f_y0, f_x1, f_y1, f_w, f_h;
  logic                   f_last;

  // Head of the queue as seen by the back end.
  logic [LABEL_BITS-1:0]  q_label;
  logic [SBG_SCORE_W-1:0] q_score;
  logic [COORD_BITS-1:0]  q_x0, q_y0, q_x1, q_y1, q_w, q_h;
  logic                   q_last;

  sbg_front #(
    .COORD_BITS (COORD_BITS),
    .LABEL_BITS (LABEL_BITS)
  ) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .f_label  (f_label),
    .f_score  (f_score),
    .f_x0     (f_x0),
    .f_y0     (f_y0),
    .f_x1     (f_x1),
    .f_y1     (f_y1),
    .f_w      (f_w),
    .f_h      (f_h),
    .f_last   (f_last)
  );

  assign q_wdata = {f_label, f_score, f_x0, f_y0, f_x1, f_y1, f_w, f_h, f_last};

  sbg_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  assign {q_label, q_score, q_x0, q_y0, q_x1, q_y1, q_w, q_h, q_last} = q_rdata;

  sbg_back #(
    .COORD_BITS (COORD_BITS),
    .LABEL_BITS (LABEL_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .q_label   (q_label),
    .q_score   (q_score),
    .q_x0      (q_x0),
    .q_y0      (q_y0),
    .q_x1      (q_x1),
    .q_y1      (q_y1),
    .q_w       (q_w),
    .q_h       (q_h),
    .q_last    (q_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .stat      (b_stat)
  );

  // The back end only pops an entry that is there.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  // The queue count never reads as full and empty at once.
  a_queue_count: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");

  // A leader is emitted only out of an open group.
  a_emit_open: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(b_stat.group_open))
    else $error("leader emitted with no group open");

  // After a pop the back end leaves its idle state.
  a_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !b_stat.idle)
    else $error("back end idle right after a pop");

endmodule

// File: rtl/sbg_front.sv
`timescale 1ns / 1ps
// Front end: accepts boxes, trims fields to the configured widths and
// computes the clamped box extents. Depends on sbg_pkg.
module sbg_front
  import sbg_pkg::*;
#(
  parameter int COORD_BITS = SBG_COORD_BITS_DEF,
  parameter int LABEL_BITS = SBG_LABEL_BITS_DEF
) (
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sbg_in_t                in_data,
  input  sbg_q_stat_t            q_stat,
  output logic                   q_push,
  output logic [LABEL_BITS-1:0]  f_label,
  output logic [SBG_SCORE_W-1:0] f_score,
  output logic [COORD_BITS-1:0]  f_x0,
  output logic [COORD_BITS-1:0]  f_y0,
  output logic [COORD_BITS-1:0]  f_x1,
  output logic [COORD_BITS-1:0]  f_y1,
  output logic [COORD_BITS-1:0]  f_w,
  output logic [COORD_BITS-1:0]  f_h,
  output logic                   f_last
);

  assign in_ready = !q_stat.full;
  assign q_push   = in_valid && in_ready;

  assign f_label = LABEL_BITS'(in_data.class_label);
  assign f_score = in_data.score;
  assign f_x0    = COORD_BITS'(in_data.box_x0);
  assign f_y0    = COORD_BITS'(in_data.box_y0);
  assign f_x1    = COORD_BITS'(in_data.box_x1);
  assign f_y1    = COORD_BITS'(in_data.box_y1);
  assign f_last  = in_data.last_box;

  // An inverted box has zero extent.
  assign f_w = (f_x1 > f_x0) ? (f_x1 - f_x0) : '0;
  assign f_h = (f_y1 > f_y0) ? (f_y1 - f_y0) : '0;

endmodule

// File: rtl/sbg_queue.sv
`timescale 1ns / 1ps
// Small register FIFO that decouples the front end from the back end.
// Depends on sbg_pkg.
module sbg_queue
  import sbg_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = SBG_QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output sbg_q_stat_t      stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rdata      = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: rtl/sbg_back.sv
`timescale 1ns / 1ps
// Back end: keeps the group leader, tests IoU on one shared multiplier
// and drives the output register. Depends on sbg_pkg.
module sbg_back
  import sbg_pkg::*;
#(
  parameter int COORD_BITS = SBG_COORD_BITS_DEF,
  parameter int LABEL_BITS = SBG_LABEL_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [SBG_THR_W-1:0]   cfg_data,
  input  sbg_q_stat_t            q_stat,
  output logic                   q_pop,
  input  logic [LABEL_BITS-1:0]  q_label,
  input  logic [SBG_SCORE_W-1:0] q_score,
  input  logic [COORD_BITS-1:0]  q_x0,
  input  logic [COORD_BITS-1:0]  q_y0,
  input  logic [COORD_BITS-1:0]  q_x1,
  input  logic [COORD_BITS-1:0]  q_y1,
  input  logic [COORD_BITS-1:0]  q_w,
  input  logic [COORD_BITS-1:0]  q_h,
  input  logic                   q_last,
  output logic                   out_valid,
  input  logic                   out_ready,
  output sbg_out_t               out_data,
  output sbg_back_stat_t         stat
);

  localparam int MW  = (COORD_BITS > SBG_THR_W) ? COORD_BITS : SBG_THR_W;
  localparam int PW  = 2 * MW;
  localparam int AW2 = 2 * COORD_BITS;
  localparam int TW  = SBG_THR_W + COORD_BITS;
  localparam int CMW = AW2 + SBG_THR_W + 1;

  localparam logic [2:0] STEP_AREA_L = 3'd0;
  localparam logic [2:0] STEP_AREA_B = 3'd1;
  localparam logic [2:0] STEP_INTER  = 3'd2;
  localparam logic [2:0] STEP_UNION  = 3'd3;
  localparam logic [2:0] STEP_TLO    = 3'd4;
  localparam logic [2:0] STEP_THI    = 3'd5;
  localparam logic [2:0] STEP_CMP    = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CALC  = 4'b0010,
    ST_APPLY = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] step_r, step_nxt;
  logic       merge_r, merge_nxt;
  logic       group_open_r, group_open_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [SBG_THR_W-1:0] thr_r;
  sbg_out_t   out_data_r;

  // Current box.
  logic [LABEL_BITS-1:0]  cur_label_r;
  logic [SBG_SCORE_W-1:0] cur_score_r;
  logic [COORD_BITS-1:0]  cur_x0_r, cur_y0_r, cur_x1_r, cur_y1_r, cur_w_r, cur_h_r;
  logic                   cur_last_r;

  // Group leader.
  logic [LABEL_BITS-1:0]  lead_label_r;
  logic [SBG_SCORE_W-1:0] lead_score_r;
  logic [COORD_BITS-1:0]  lead_x0_r, lead_y0_r, lead_x1_r, lead_y1_r, lead_w_r, lead_h_r;

  // IoU datapath.
  logic [COORD_BITS-1:0] iw_r, ih_r;
  logic [AW2-1:0]        area_l_r, area_b_r, inter_r, uni_r;
  logic [TW-1:0]         tlo_r, thi_r;

  logic [COORD_BITS-1:0] ix_lo, ix_hi, iy_lo, iy_hi, iw, ih;
  logic [MW-1:0]         mul_a, mul_b;
  logic [PW-1:0]         mul_p;
  logic [AW2:0]          uni_sum;
  logic [CMW-1:0]        cmp_lhs, cmp_rhs;
  logic                  cmp_merge;

  logic out_free, close_grp, take_lead, out_load, emit_last;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign stat.group_open = group_open_r;
  assign stat.idle       = (state_r == ST_IDLE);

  // Overlap rectangle, clamped at zero.
  assign ix_lo = (lead_x0_r > cur_x0_r) ? lead_x0_r : cur_x0_r;
  assign ix_hi = (lead_x1_r < cur_x1_r) ? lead_x1_r : cur_x1_r;
  assign iy_lo = (lead_y0_r > cur_y0_r) ? lead_y0_r : cur_y0_r;
  assign iy_hi = (lead_y1_r < cur_y1_r) ? lead_y1_r : cur_y1_r;
  assign iw    = (ix_hi > ix_lo) ? (ix_hi - ix_lo) : '0;
  assign ih    = (iy_hi > iy_lo) ? (iy_hi - iy_lo) : '0;

  always_comb begin
    unique case (step_r)
      STEP_AREA_L: begin
        mul_a = MW'(lead_w_r);
        mul_b = MW'(lead_h_r);
      end
      STEP_AREA_B: begin
        mul_a = MW'(cur_w_r);
        mul_b = MW'(cur_h_r);
      end
      STEP_INTER: begin
        mul_a = MW'(iw_r);
        mul_b = MW'(ih_r);
      end
      STEP_TLO: begin
        mul_a = MW'(thr_r);
        mul_b = MW'(uni_r[COORD_BITS-1:0]);
      end
      STEP_THI: begin
        mul_a = MW'(thr_r);
        mul_b = MW'(uni_r[AW2-1:COORD_BITS]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign uni_sum = ({1'b0, area_l_r} + {1'b0, area_b_r}) - {1'b0, inter_r};

  // inter * 2^16 >= threshold * union, with the union rebuilt from halves.
  assign cmp_lhs   = CMW'(inter_r) << SBG_THR_W;
  assign cmp_rhs   = (CMW'(thi_r) << COORD_BITS) + CMW'(tlo_r);
  assign cmp_merge = (uni_r == '0) ? (thr_r == '0) : (cmp_lhs >= cmp_rhs);

  assign out_free  = !out_valid_r || out_ready;
  assign close_grp = group_open_r && !merge_r;

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    merge_nxt      = merge_r;
    group_open_nxt = group_open_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    q_pop          = 1'b0;
    take_lead      = 1'b0;
    out_load       = 1'b0;
    emit_last      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          q_pop = 1'b1;
          if (!group_open_r || (q_label != lead_label_r)) begin
            merge_nxt = 1'b0;
            state_nxt = ST_APPLY;
          end else begin
            step_nxt  = STEP_AREA_L;
            state_nxt = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        if (step_r == STEP_CMP) begin
          merge_nxt = cmp_merge;
          state_nxt = ST_APPLY;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_APPLY: begin
        if (!close_grp || out_free) begin
          out_load       = close_grp;
          take_lead      = !group_open_r || close_grp || (lead_score_r < cur_score_r);
          group_open_nxt = 1'b1;
          state_nxt      = cur_last_r ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_load       = 1'b1;
          emit_last      = 1'b1;
          group_open_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= STEP_AREA_L;
      merge_r      <= 1'b0;
      group_open_r <= 1'b0;
      out_valid_r  <= 1'b0;
      thr_r        <= SBG_THR_RESET;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      merge_r      <= merge_nxt;
      group_open_r <= group_open_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid) begin
        thr_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_label_r <= q_label;
      cur_score_r <= q_score;
      cur_x0_r    <= q_x0;
      cur_y0_r    <= q_y0;
      cur_x1_r    <= q_x1;
      cur_y1_r    <= q_y1;
      cur_w_r     <= q_w;
      cur_h_r     <= q_h;
      cur_last_r  <= q_last;
    end
    if (state_r == ST_CALC) begin
      unique case (step_r)
        STEP_AREA_L: begin
          area_l_r <= AW2'(mul_p);
          iw_r     <= iw;
          ih_r     <= ih;
        end
        STEP_AREA_B: area_b_r <= AW2'(mul_p);
        STEP_INTER:  inter_r  <= AW2'(mul_p);
        STEP_UNION:  uni_r    <= AW2'(uni_sum);
        STEP_TLO:    tlo_r    <= TW'(mul_p);
        STEP_THI:    thi_r    <= TW'(mul_p);
        default: begin
        end
      endcase
    end
    if (out_load) begin
      out_data_r.out_label <= SBG_LABEL_W'(lead_label_r);
      out_data_r.out_score <= lead_score_r;
      out_data_r.out_x0    <= SBG_COORD_W'(lead_x0_r);
      out_data_r.out_y0    <= SBG_COORD_W'(lead_y0_r);
      out_data_r.out_x1    <= SBG_COORD_W'(lead_x1_r);
      out_data_r.out_y1    <= SBG_COORD_W'(lead_y1_r);
      out_data_r.out_last  <= emit_last;
    end
    if (take_lead) begin
      lead_label_r <= cur_label_r;
      lead_score_r <= cur_score_r;
      lead_x0_r    <= cur_x0_r;
      lead_y0_r    <= cur_y0_r;
      lead_x1_r    <= cur_x1_r;
      lead_y1_r    <= cur_y1_r;
      lead_w_r     <= cur_w_r;
      lead_h_r     <= cur_h_r;
    end
  end

endmodule

// File: dv/sequential_box_grouping_nms_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sequential_box_grouping_nms_core: directed boxes, then random
// images under several IoU thresholds, with random stalls on the box and leader channels.
// Depends on sbg_pkg and the block's RTL; a scoreboard class predicts every emitted leader.
module sequential_box_grouping_nms_core_tb;
  import sbg_pkg::*;

  // The watchdog limit is several times the slowest legal run: every box with its longest
  // input gap, a full back-end pass, and two leaders that each wait out the longest stall.
  localparam int CYCLE_LIMIT  = 1000000;
  // Boxes that emit nothing may still sit in the queue or the back end once the last
  // expected leader has arrived; one box in the back end and two queued fit well
  // inside this.
  localparam int DRAIN_CYCLES = 64;
  // Random boxes per threshold setting; five settings give the bulk of the run.
  localparam int PHASE_BOXES  = 230;

  // Scoreboard: a model of the grouping block with its own copy of the threshold and
  // of the open group, plus the queue of leaders it expects to see on the output.
  class leader_board;
    logic [SBG_THR_W-1:0] threshold;
    bit                   group_open;
    sbg_in_t              leader;
    sbg_out_t             owed[$];
    int                   errors;

    function new();
      threshold  = SBG_THR_RESET;
      group_open = 1'b0;
      leader     = '0;
      errors     = 0;
    endfunction

    function void set_threshold(logic [SBG_THR_W-1:0] value);
      threshold = value;
    endfunction

    // Extent of one side; an inverted side counts as zero.
    function logic [63:0] span(logic [15:0] lo, logic [15:0] hi);
      return (hi > lo) ? 64'(hi - lo) : 64'd0;
    endfunction

    // Exact IoU test by cross-multiplication against the Q0.16 threshold.
    function bit overlaps_enough(sbg_in_t b);
      logic [63:0] area_l, area_b, inter, union_area;
      logic [15:0] lo_x, hi_x, lo_y, hi_y;
      lo_x   = (leader.box_x0 > b.box_x0) ? leader.box_x0 : b.box_x0;
      hi_x   = (leader.box_x1 < b.box_x1) ? leader.box_x1 : b.box_x1;
      lo_y   = (leader.box_y0 > b.box_y0) ? leader.box_y0 : b.box_y0;
      hi_y   = (leader.box_y1 < b.box_y1) ? leader.box_y1 : b.box_y1;
      area_l = span(leader.box_x0, leader.box_x1) * span(leader.box_y0, leader.box_y1);
      area_b = span(b.box_x0, b.box_x1) * span(b.box_y0, b.box_y1);
      inter  = span(lo_x, hi_x) * span(lo_y, hi_y);
      union_area = area_l + area_b - inter;
      if (union_area == 64'd0) begin
        return threshold == '0;
      end
      return (inter << 16) >= 64'(threshold) * union_area;
    endfunction

    function void emit_leader(bit is_last);
      sbg_out_t r;
      r.out_label = leader.class_label;
      r.out_score = leader.score;
      r.out_x0    = leader.box_x0;
      r.out_y0    = leader.box_y0;
      r.out_x1    = leader.box_x1;
      r.out_y1    = leader.box_y1;
      r.out_last  = is_last;
      owed.insert(owed.size(), r);
    endfunction

    // Called for every accepted box transfer.
    function void note_box(sbg_in_t b);
      if (!group_open) begin
        leader     = b;
        group_open = 1'b1;
      end else if (b.class_label == leader.class_label && overlaps_enough(b)) begin
        if (leader.score < b.score) begin
          leader = b;
        end
      end else begin
        emit_leader(1'b0);
        leader = b;
      end
      if (b.last_box) begin
        emit_leader(1'b1);
        group_open = 1'b0;
      end
    endfunction

    function void check_field(string name, logic [15:0] exp, logic [15:0] act);
      if (exp !== act) begin
        $error("%s: expected %0d, actual %0d", name, exp, act);
        errors++;
      end
    endfunction

    // Called for every accepted leader transfer.
    function void check_leader(sbg_out_t got);
      sbg_out_t exp;
      if (owed.size() == 0) begin
        $error("leader transfer with none expected: label %0d score %0d",
               got.out_label, got.out_score);
        errors++;
        return;
      end
      exp = owed.pop_front();
      check_field("out_label", 16'(exp.out_label), 16'(got.out_label));
      check_field("out_score", exp.out_score, got.out_score);
      check_field("out_x0", exp.out_x0, got.out_x0);
      check_field("out_y0", exp.out_y0, got.out_y0);
      check_field("out_x1", exp.out_x1, got.out_x1);
      check_field("out_y1", exp.out_y1, got.out_y1);
      check_field("out_last", 16'(exp.out_last), 16'(got.out_last));
    endfunction

    function int waiting();
      return owed.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  sbg_in_t              in_data;
  logic                 out_valid;
  logic                 out_ready;
  sbg_out_t             out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [SBG_THR_W-1:0] cfg_data;

  leader_board board = new();
  int          cycles = 0;
  int          stall_left;
  // While calm is set, neither side idles, so back-to-back transfers get exercised.
  bit          calm;
  // The box that the current image clusters around, and the score of the previous box,
  // which is reused now and then so that score ties with the leader come up.
  sbg_in_t     anchor;
  logic [15:0] prev_score;

  sequential_box_grouping_nms_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Watchdog: a hung handshake or a leader that never comes ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sequential_box_grouping_nms_core regression: fail");
      $finish;
    end
  end

  // Length of one idle stretch, from three ranges: the shortest most often, the longest rarely.
  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end else if (r < 95) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic int in_gap();
    if (calm || $urandom_range(0, 1) == 0) begin
      return 0;
    end
    return stall_len();
  endfunction

  // Leader side: out_ready changes only at the falling edge, and a transfer is taken
  // from what the rising edge sees.
  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        board.check_leader(out_data);
      end
      @(negedge clk);
      if (calm) begin
        stall_left = 0;
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 99) < 25) begin
          stall_left = stall_len();
        end
      end
    end
  end

  function automatic sbg_in_t mk_box(int lbl, int sc, int x0, int y0, int x1, int y1,
                                     bit is_last);
    sbg_in_t b;
    b.class_label = 8'(lbl);
    b.score       = 16'(sc);
    b.box_x0      = 16'(x0);
    b.box_y0      = 16'(y0);
    b.box_x1      = 16'(x1);
    b.box_y1      = 16'(y1);
    b.last_box    = is_last;
    return b;
  endfunction

  // Any box at all: every bit of every field is free.
  function automatic sbg_in_t random_box();
    sbg_in_t b;
    b.class_label = 8'($urandom);
    b.score       = 16'($urandom);
    b.box_x0      = 16'($urandom);
    b.box_y0      = 16'($urandom);
    b.box_x1      = 16'($urandom);
    b.box_y1      = 16'($urandom);
    b.last_box    = 1'($urandom_range(0, 1));
    return b;
  endfunction

  // Picks a fresh cluster center. Most are small boxes near the origin from a handful
  // of classes, so that same-class overlaps are common; some spread over the frame.
  function automatic void new_anchor();
    int x0, y0;
    anchor.class_label = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    if ($urandom_range(0, 9) == 0) begin
      x0 = $urandom_range(8, 40000);
      y0 = $urandom_range(8, 40000);
      anchor.box_x1 = 16'(x0 + $urandom_range(1, 25000));
      anchor.box_y1 = 16'(y0 + $urandom_range(1, 25000));
    end else begin
      x0 = $urandom_range(8, 3000);
      y0 = $urandom_range(8, 3000);
      anchor.box_x1 = 16'(x0 + $urandom_range(1, 700));
      anchor.box_y1 = 16'(y0 + $urandom_range(1, 700));
    end
    anchor.box_x0 = 16'(x0);
    anchor.box_y0 = 16'(y0);
  endfunction

  // Next box of a well-formed image: mostly exact or near copies of the anchor so that groups
  // form and break, with degenerate boxes, new clusters and stray boxes.
  function automatic sbg_in_t next_box(bit is_last);
    sbg_in_t b;
    int      pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      b = random_box();
    end else begin
      if (pick >= 60 && pick < 75) begin
        new_anchor();
      end
      b = anchor;
      if (pick < 50) begin
        b.box_x0 = 16'(anchor.box_x0 + $urandom_range(0, 16) - 8);
        b.box_y0 = 16'(anchor.box_y0 + $urandom_range(0, 16) - 8);
        b.box_x1 = 16'(anchor.box_x1 + $urandom_range(0, 16) - 8);
        b.box_y1 = 16'(anchor.box_y1 + $urandom_range(0, 16) - 8);
      end else if (pick < 60) begin
        // Inverted or flat box: zero area.
        b.box_x1 = 16'(b.box_x0 - $urandom_range(0, 40));
      end
      if ($urandom_range(0, 4) == 0) begin
        b.class_label = 8'($urandom_range(0, 3));
      end
      b.score = ($urandom_range(0, 9) == 0) ? prev_score : 16'($urandom);
    end
    b.last_box = is_last;
    prev_score = b.score;
    return b;
  endfunction

  // Box side. Called at a falling edge and returns at the falling edge after the
  // transfer, with in_valid still high; the next call either keeps it high with new
  // data or lowers it for the gap, so in_valid gets one assignment per time step.
  task automatic send_box(sbg_in_t b, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    board.note_box(b);
    @(negedge clk);
  endtask

  // Holds the box side off until every expected leader has arrived, then lets the
  // boxes that emit nothing drain out of the block.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.waiting() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Only called with the block idle, so the new threshold applies from the next box on.
  task automatic write_threshold(logic [SBG_THR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    board.set_threshold(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Directed boxes for the grouping rules, the degenerate geometries and the extremes.
  task automatic run_directed();
    // Threshold still at its reset value of 0.80.
    send_box(mk_box(1, 100, 0, 0, 160, 160, 0), 0);     // first box opens a group
    send_box(mk_box(1, 200, 0, 0, 160, 160, 0), 0);     // same box, higher score: new leader
    send_box(mk_box(1, 200, 0, 0, 160, 160, 0), 2);     // score tie keeps the old leader
    send_box(mk_box(1, 50, 8, 0, 168, 160, 0), 0);      // IoU 0.90 joins, leader stays
    send_box(mk_box(1, 300, 100, 100, 260, 260, 0), 0); // weak overlap closes the group
    send_box(mk_box(2, 300, 100, 100, 260, 260, 0), 0); // same box, other class closes it
    send_box(mk_box(2, 10, 260, 100, 100, 260, 0), 1);  // inverted box has zero area
    send_box(mk_box(2, 10, 50, 50, 50, 90, 0), 0);      // zero union does not merge
    send_box(mk_box(2, 20, 50, 50, 50, 90, 1), 0);      // close and flush: two leaders
    send_box(mk_box(255, 65535, 0, 0, 65535, 65535, 1), 0); // last box with no group
    send_box(mk_box(0, 0, 65535, 65535, 0, 0, 0), 0);
    send_box(mk_box(0, 0, 0, 0, 0, 0, 1), 3);
    wait_idle();
    // Threshold zero: any same-class box joins, even one with zero union.
    write_threshold('0);
    send_box(mk_box(3, 5, 10, 10, 10, 10, 0), 0);
    send_box(mk_box(3, 6, 20, 20, 20, 20, 0), 0);
    send_box(mk_box(3, 7, 0, 0, 100, 100, 0), 0);
    send_box(mk_box(4, 1, 0, 0, 100, 100, 0), 0);
    send_box(mk_box(4, 1, 30000, 30000, 65535, 65535, 1), 0);
    wait_idle();
    // Largest threshold: only an identical box joins.
    write_threshold('1);
    send_box(mk_box(7, 1000, 16, 16, 4096, 4096, 0), 0);
    send_box(mk_box(7, 2000, 16, 16, 4096, 4096, 0), 0);
    send_box(mk_box(7, 3000, 16, 16, 4096, 4095, 0), 0);
    send_box(mk_box(7, 0, 16, 16, 4096, 4095, 1), 0);
  endtask

  // Random images until count boxes have gone in. Most images are well formed and end
  // on a last box; about one in ten is noise with last boxes anywhere.
  task automatic run_images(int count);
    int      done, len, k;
    bit      noise;
    sbg_in_t b;
    done = 0;
    while (done < count) begin
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      noise = ($urandom_range(0, 9) == 0);
      calm  = ($urandom_range(0, 6) == 0);
      new_anchor();
      for (k = 0; k < len; k++) begin
        b = noise ? random_box() : next_box(k == len - 1);
        send_box(b, in_gap());
        done++;
      end
      // Now and then the sender waits for every expected leader before going on.
      if ($urandom_range(0, 19) == 0) begin
        wait_idle();
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    logic [SBG_THR_W-1:0] settings[5];
    int                   p;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    calm       = 1'b0;
    anchor     = '0;
    prev_score = '0;
    settings[0] = 16'($urandom);
    settings[1] = 16'h8000;
    settings[2] = '0;
    settings[3] = '1;
    settings[4] = SBG_THR_RESET;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();
    for (p = 0; p < 5; p++) begin
      wait_idle();
      write_threshold(settings[p]);
      run_images(PHASE_BOXES);
    end

    // Every leader has arrived once wait_idle returns; the drain cycles it adds
    // catch any transfer that comes with nothing expected.
    wait_idle();
    if (board.errors == 0) begin
      $display("sequential_box_grouping_nms_core regression: pass");
    end else begin
      $display("sequential_box_grouping_nms_core regression: fail");
    end
    $finish;
  end

endmodule
